// ----- design/mtkc_pkg.sv -----
// mtkc_pkg: shared constants and the character table of the multi-tap keypad decoder
// no dependencies; used by mtkc_lookup and multitap_key_to_char
`default_nettype none

package mtkc_pkg;

  // stored character table size
  localparam int unsigned TabRows = 10;
  localparam int unsigned TabCols = 9;

  // idle counter saturation point and commit delay after reset
  localparam logic [7:0] IdleLimit        = 8'h80;
  localparam logic [6:0] CommitDelayReset = 7'd8;

  // multi-tap character table, row = key - 1, column = press count plus shift offset
  localparam logic [7:0] CharTable [TabRows][TabCols] = '{
    '{"0", " ", ".", ",", ")", "+", "?", "_", ":"},
    '{"1", "a", "b", "c", "!", "A", "B", "C", "~"},
    '{"2", "d", "e", "f", "@", "D", "E", "F", "{"},
    '{"3", "g", "h", "i", "#", "G", "H", "I", "}"},
    '{"4", "j", "k", "l", "$", "J", "K", "L", "["},
    '{"5", "m", "n", "o", "%", "M", "N", "O", "]"},
    '{"6", "p", "q", "r", "^", "P", "Q", "R", "|"},
    '{"7", "s", "t", "u", "&", "S", "T", "U", "/"},
    '{"8", "v", "w", "x", "*", "V", "W", "X", "<"},
    '{"9", "y", "z", "(", "-", "Y", "Z", "=", ">"}
  };

endpackage

`default_nettype wire

// ----- design/mtkc_lookup.sv -----
// mtkc_lookup: bounds-checked character table read
// depends on mtkc_pkg for the table and its size
`default_nettype none

module mtkc_lookup #(
  parameter int unsigned ROWS = 10,
  parameter int unsigned COLS = 9
) (
  input  wire logic [3:0] row_i,
  input  wire logic [4:0] col_i,
  output logic      [7:0] char_o
);
  import mtkc_pkg::*;

  logic in_range;

  // positions outside the configured or stored table read as zero
  assign in_range = (32'(row_i) < ROWS) && (32'(col_i) < COLS) &&
                    (32'(row_i) < TabRows) && (32'(col_i) < TabCols);

  always_comb begin
    char_o = 8'h00;
    if (in_range) begin
      char_o = CharTable[row_i][col_i[3:0]];
    end
  end

endmodule

`default_nettype wire

// ----- design/multitap_key_to_char.sv -----
// multitap_key_to_char: multi-tap keypad text entry, one scan tick per transfer
// a committing tick is held in the input register, then its character in the result register
// throughput: one tick per cycle unless the master stalls, set by the single state update
// between input and result register; a stalled output still lets the input register take a tick
// reset: asynchronous active low; clears pending key, idle counter, valid flags, delay to 8
// depends on mtkc_pkg and mtkc_lookup
`default_nettype none

module multitap_key_to_char #(
  parameter int unsigned ROWS         = 10,
  parameter int unsigned COLS         = 9,
  parameter int unsigned SHIFT_OFFSET = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration: commit_delay
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  // scan tick input
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [3:0] key_code, [7:4] zero
  input  wire logic       s_axis_tuser,   // [0] shift_held
  // character output
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata    // [7:0] char_code
);
  import mtkc_pkg::*;

  localparam int          Modulus  = int'(COLS) - int'(SHIFT_OFFSET);
  localparam logic [3:0]  RowsW    = 4'(ROWS);
  localparam logic [4:0]  ModW     = (Modulus < 1) ? 5'd0 : 5'(Modulus);
  localparam logic [4:0]  ShiftW   = 5'(SHIFT_OFFSET);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [3:0] key_q;
  logic       shift_q;

  // tap state
  logic [6:0] commit_delay_q;
  logic [7:0] idle_q, idle_d;
  logic       pend_valid_q, pend_valid_d;
  logic [3:0] pend_row_q, pend_row_d;
  logic [2:0] count_q, count_d;
  logic       pend_shift_q, pend_shift_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;

  logic       advance;
  logic       proc;
  logic       key_ok;
  logic [3:0] row;
  logic [3:0] count_inc;
  logic       commit;
  logic [4:0] col;
  logic [7:0] char_rd;
  logic       in_xfer;

  // handshake
  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;

  // decode of the registered tick
  assign key_ok    = (key_q != 4'd0) && (key_q <= RowsW);
  assign row       = key_q - 4'd1;
  assign count_inc = {1'b0, count_q} + 4'd1;
  assign commit    = !key_ok && pend_valid_q && (idle_q > {1'b0, commit_delay_q});
  assign col       = {2'b00, count_q} + (pend_shift_q ? ShiftW : 5'd0);

  mtkc_lookup #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_lookup (
    .row_i  (pend_row_q),
    .col_i  (col),
    .char_o (char_rd)
  );

  // next tap state
  always_comb begin
    idle_d       = idle_q;
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    count_d      = count_q;
    pend_shift_d = pend_shift_q;
    if (proc) begin
      if (key_ok) begin
        idle_d = 8'd0;
        if (pend_valid_q && (pend_row_q == row)) begin
          // count stays below the modulus, so one compare does the wrap
          if (ModW == 5'd0 || {1'b0, count_inc} == ModW) begin
            count_d = 3'd0;
          end else begin
            count_d = count_inc[2:0];
          end
        end else begin
          pend_valid_d = 1'b1;
          pend_row_d   = row;
          count_d      = 3'd0;
          pend_shift_d = shift_q;
        end
      end else if (commit) begin
        pend_valid_d = 1'b0;
        pend_row_d   = 4'd0;
        count_d      = 3'd0;
        pend_shift_d = 1'b0;
      end
      // saturating idle count, applied after any clear
      if ((idle_d & IdleLimit) == 8'd0) begin
        idle_d = idle_d + 8'd1;
      end
    end
  end

  // valid flags of the two registers
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = commit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      commit_delay_q <= CommitDelayReset;
      idle_q         <= 8'd0;
      pend_valid_q   <= 1'b0;
      pend_row_q     <= 4'd0;
      count_q        <= 3'd0;
      pend_shift_q   <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      idle_q       <= idle_d;
      pend_valid_q <= pend_valid_d;
      pend_row_q   <= pend_row_d;
      count_q      <= count_d;
      pend_shift_q <= pend_shift_d;
      if (cfg_we_i) begin
        commit_delay_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q   <= s_axis_tdata[3:0];
      shift_q <= s_axis_tuser;
    end
    if (proc && commit) begin
      out_char_q <= char_rd;
    end
  end

  // idle counter never passes its saturation point
  assert property (@(posedge clk_i) disable iff (!rst_ni) idle_q <= IdleLimit)
    else $error("idle counter above saturation");

  // with nothing pending the pending fields are cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_valid_q |-> (pend_row_q == 4'd0 && count_q == 3'd0 && !pend_shift_q))
    else $error("stale pending fields");

  // a processed key press leaves a pending key and an idle count of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && key_ok) |=> (pend_valid_q && idle_q == 8'd1))
    else $error("key press not registered");

  // a commit presents a character and clears the pending key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && commit) |=> (m_axis_tvalid && !pend_valid_q))
    else $error("commit lost");

  // press count stays below a small modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ModW != 5'd0 && ModW <= 5'd8) |-> ({2'b00, count_q} < ModW))
    else $error("press count out of range");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench for multitap_key_to_char, the multi-tap keypad decoder
// drives scan ticks and delay settings, predicts every committed character and checks them
// depends on mtkc_pkg and the multitap_key_to_char design files

module tb;
  import mtkc_pkg::*;

  localparam int unsigned ROWS         = 10;
  localparam int unsigned COLS         = 9;
  localparam int unsigned SHIFT_OFFSET = 4;
  localparam int          CountMod     = int'(COLS) - int'(SHIFT_OFFSET);
  localparam int          SettleCycles = 6;
  localparam int          HoldCycles   = 300;
  localparam int          StallLimit   = 3000;

  typedef struct packed {
    logic [3:0] key;
    logic       shift;
  } tick_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [6:0] cfg_wdata_i   = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // predicted decoder state and delay setting
  logic [7:0] idle_ticks;
  logic       pend_valid;
  logic [3:0] pend_row;
  logic [2:0] press_cnt;
  logic       pend_shift;
  logic [6:0] commit_dly;

  tick_t      tick_q [$];
  logic [7:0] char_q [$];
  int         n_queued;
  int         n_accepted;
  int         n_chars;
  int         n_errors;
  int         n_settings;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_cycles;
  int         hold_cnt;
  bit         pressure_arm;
  bit         pressure_done;

  multitap_key_to_char #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .SHIFT_OFFSET(SHIFT_OFFSET)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [3:0] key_code, [7:4] zero
    .s_axis_tuser (s_axis_tuser),   // [0] shift_held
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [7:0] char_code
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one scan tick of the decoder: returns 1 when a character is committed
  function automatic logic decode_tick(input logic [3:0] key, input logic shift,
                                       output logic [7:0] ch);
    logic        fire;
    int unsigned col;
    fire = 1'b0;
    ch   = '0;
    if (key >= 1 && key <= ROWS) begin
      idle_ticks = '0;
      if (pend_valid && pend_row == key - 4'd1) begin
        press_cnt = (CountMod < 1) ? 3'd0 : 3'((int'(press_cnt) + 1) % CountMod);
      end else begin
        pend_valid = 1'b1;
        pend_row   = key - 4'd1;
        press_cnt  = '0;
        pend_shift = shift;
      end
    end else if (pend_valid && idle_ticks > {1'b0, commit_dly}) begin
      col = press_cnt + (pend_shift ? SHIFT_OFFSET : 0);
      if (pend_row < ROWS && col < COLS && pend_row < TabRows && col < TabCols) begin
        ch = CharTable[pend_row][col];
      end
      fire       = 1'b1;
      pend_valid = 1'b0;
      pend_row   = '0;
      press_cnt  = '0;
      pend_shift = 1'b0;
    end
    // idle counter saturates once its top bit is set
    if ((idle_ticks & IdleLimit) == '0) begin
      idle_ticks = idle_ticks + 8'd1;
    end
    return fire;
  endfunction

  function automatic void note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // scan tick driver
  always @(posedge clk_i) begin : drv
    tick_t t;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        t = tick_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, t.key};
        s_axis_tuser  <= t.shift;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // character receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (pressure_arm && !pressure_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= HoldCycles;
      pressure_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check characters against predictions, then predict the accepted tick
  always @(posedge clk_i) begin : mon
    logic [7:0] want;
    logic [7:0] ch;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_chars++;
        if (char_q.size() == 0) begin
          note_error($sformatf("unexpected character %h", m_axis_tdata));
        end else begin
          want = char_q.pop_front();
          if (want !== m_axis_tdata) begin
            note_error($sformatf("char_code expected %h got %h", want, m_axis_tdata));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_accepted++;
        if (decode_tick(s_axis_tdata[3:0], s_axis_tuser, ch)) begin
          char_q.push_back(ch);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", stall_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_tick(input int key, input int shift);
    tick_t t;
    t.key   = 4'(key);
    t.shift = 1'(shift);
    tick_q.push_back(t);
    n_queued++;
  endtask

  task automatic set_delay(input logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    commit_dly   = v;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // all ticks accepted and all characters seen, then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk_i); while (n_accepted != n_queued || char_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // random words: key presses with repeats, then an idle run around the delay; some noise
  task automatic run_phase(input int n_items);
    int start;
    int key;
    int presses;
    int idle_len;
    int d;
    int r;
    start = n_queued;
    d     = commit_dly;
    while (n_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        key     = $urandom_range(1, ROWS);
        presses = $urandom_range(1, 8);
        for (int i = 0; i < presses; i++) begin
          if ($urandom_range(0, 99) < 8) begin
            key = $urandom_range(1, ROWS);
          end
          queue_tick(key, $urandom_range(0, 1));
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          idle_len = d + 1 + $urandom_range(0, 3);
        end else if (r < 90) begin
          idle_len = $urandom_range(0, d);
        end else begin
          idle_len = d + $urandom_range(4, 20);
        end
        for (int i = 0; i < idle_len; i++) begin
          if ($urandom_range(0, 99) < 20) begin
            queue_tick($urandom_range(ROWS + 1, 15), $urandom_range(0, 1));
          end else begin
            queue_tick(0, $urandom_range(0, 1));
          end
        end
      end else begin
        presses = $urandom_range(1, 6);
        for (int i = 0; i < presses; i++) begin
          queue_tick($urandom_range(0, 15), $urandom_range(0, 1));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    int delays [12];
    delays     = '{8, 0, 3, 127, 1, 6, 0, 2, 11, 4, 1, 0};
    delays[11] = $urandom_range(0, 10);
    idle_ticks = '0;
    pend_valid = 1'b0;
    pend_row   = '0;
    press_cnt  = '0;
    pend_shift = 1'b0;
    commit_dly = CommitDelayReset;
    send_idle_pct = 22;
    recv_idle_pct = 54;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: commit at zero delay, top key with shift, count wrap with shift
    // ignored on repeat, key replacement, out-of-range keys as idle ticks
    set_delay(7'd0);
    queue_tick(1, 0);  queue_tick(0, 0);
    queue_tick(10, 1); queue_tick(0, 0);
    queue_tick(5, 0);  queue_tick(5, 1); queue_tick(5, 0);
    queue_tick(5, 0);  queue_tick(5, 1); queue_tick(5, 0); queue_tick(0, 0);
    queue_tick(2, 1);  queue_tick(3, 0); queue_tick(0, 0);
    queue_tick(15, 0); queue_tick(7, 1); queue_tick(11, 1); queue_tick(0, 0);
    queue_tick(0, 0);  queue_tick(9, 1); queue_tick(9, 0); queue_tick(9, 1);
    queue_tick(0, 1);
    wait_drained();

    // random phases over a range of delays; the first reverts to the reset value
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 22;
        recv_idle_pct = 54;
      end else if (p < 8) begin
        send_idle_pct = 54;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_delay(7'(delays[p]));
      run_phase(delays[p] == 127 ? 250 : 115);
    end

    // back-pressure: dense commits while the receiver holds off
    set_delay(7'd0);
    pressure_arm = 1'b1;
    for (int i = 0; i < 60; i++) begin
      queue_tick($urandom_range(1, ROWS), $urandom_range(0, 1));
      queue_tick(0, $urandom_range(0, 1));
    end
    wait_drained();

    if (char_q.size() != 0) begin
      note_error($sformatf("%0d characters never arrived", char_q.size()));
    end
    $display("covered %0d scan ticks and %0d committed characters over %0d delay settings",
             n_accepted, n_chars, n_settings);
    $display("including idle-counter saturation and a %0d-cycle output hold-off", HoldCycles);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
